// ===== rtl/gdfs_pkg.sv =====
// Package for the depth-first path search block.
// Holds sizes, result kind codes, controller states and the command/status structs.
// No dependencies.
package gdfs_pkg;
    localparam int VERTICES  = 16;
    localparam int VW        = 4;
    localparam int CNT_W     = 5;
    localparam int COST_BITS = 16;
    localparam int SUM_BITS  = 20;

    localparam logic [1:0] KIND_PATH = 2'd0;
    localparam logic [1:0] KIND_SUM  = 2'd1;
    localparam logic [1:0] KIND_VIS  = 2'd2;
    localparam logic [1:0] KIND_GEN  = 2'd3;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE, S_STEP, S_SCAN, S_DECIDE, S_PUSH,
        S_OUT_PATH, S_OUT_SUM, S_OUT_VIS, S_OUT_GEN, S_OUT_BAD
    } t_state;

    typedef struct packed {
        logic load;
        logic init;
        logic scan_start;
        logic scan;
        logic push;
        logic pop;
        logic set_found;
        logic emit_path;
        logic emit_sum;
        logic emit_vis;
        logic emit_gen;
        logic emit_bad;
    } t_dp_cmd;

    typedef struct packed {
        logic             in_range;
        logic             stack_empty;
        logic             top_is_goal;
        logic             scan_last;
        logic             push_ok;
        logic             path_last;
        logic             vis_last;
        logic             gen_last;
        logic             out_free;
        logic             found;
        logic [CNT_W-1:0] depth;
    } t_dp_stat;
endpackage

// ===== rtl/gdfs_in_if.sv =====
// Input channel of the path search block: handshake plus one input word.
// Depends on gdfs_pkg.
interface gdfs_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [gdfs_pkg::VW-1:0]     vertex_a;
    logic [gdfs_pkg::VW-1:0]     vertex_b;
    logic [15:0]                 edge_cost;
    logic                        edge_present;

    modport source(output valid, operation, vertex_a, vertex_b, edge_cost, edge_present,
                   input ready);
    modport sink(input valid, operation, vertex_a, vertex_b, edge_cost, edge_present,
                 output ready);
endinterface

// ===== rtl/gdfs_out_if.sv =====
// Result channel of the path search block: handshake plus one result word.
// Depends on gdfs_pkg.
interface gdfs_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      list_kind;
    logic [gdfs_pkg::VW-1:0]         vertex;
    logic [gdfs_pkg::SUM_BITS-1:0]   path_cost;
    logic                            path_found;
    logic                            last;

    modport source(output valid, list_kind, vertex, path_cost, path_found, last,
                   input ready);
    modport sink(input valid, list_kind, vertex, path_cost, path_found, last,
                 output ready);
endinterface

// ===== rtl/graph_depth_first_path_search.sv =====
// Top level of the depth-first path search block: register port, controller, datapath.
// Depends on gdfs_pkg, gdfs_in_if, gdfs_out_if, gdfs_ctrl and gdfs_dpath.
//
//   channel   direction  contents
//   s_in      in         load edge word or search word
//   m_out     out        path, summary, visited and generated list words
//   APB       in/out     vertex_count register at byte address 0
//
// A load word is taken in the idle state. A search examines one neighbor per cycle:
// a step that pops passes through the step, scan and decide states, one that pushes
// also through the push state, and the goal step through the step state alone.
// Reset is synchronous and clears the graph; the result register stalls the
// search output only, and the next word is taken once the last result is loaded.
module graph_depth_first_path_search (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gdfs_in_if.sink       s_in,
    gdfs_out_if.source    m_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import gdfs_pkg::*;

    logic [CNT_W-1:0] r_vcount;
    logic [CNT_W-1:0] count;
    t_dp_cmd          cmd;
    t_dp_stat         stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= CNT_W'(VERTICES);
        end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
            r_vcount <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {{(32-CNT_W){1'b0}}, r_vcount} : '0;

    always_comb begin
        if (r_vcount < CNT_W'(2)) count = CNT_W'(2);
        else if (r_vcount > CNT_W'(VERTICES)) count = CNT_W'(VERTICES);
        else count = r_vcount;
    end

    gdfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_in.valid),
        .i_in_op    (s_in.operation),
        .o_in_ready (s_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gdfs_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_count        (count),
        .i_vertex_a     (s_in.vertex_a),
        .i_vertex_b     (s_in.vertex_b),
        .i_edge_cost    (s_in.edge_cost),
        .i_edge_present (s_in.edge_present),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (m_out.ready),
        .o_out_valid    (m_out.valid),
        .o_list_kind    (m_out.list_kind),
        .o_vertex       (m_out.vertex),
        .o_path_cost    (m_out.path_cost),
        .o_path_found   (m_out.path_found),
        .o_last         (m_out.last)
    );

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.depth <= CNT_W'(VERTICES))
        else $error("path stack depth above vertex limit");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.valid && s_in.ready && s_in.operation == OP_SEARCH |=> !s_in.ready)
        else $error("search word did not occupy the block");

    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.valid && s_in.ready && s_in.operation == OP_LOAD |=> s_in.ready)
        else $error("load word held the block");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && m_out.last |-> m_out.list_kind == KIND_SUM
                                       || m_out.list_kind == KIND_GEN)
        else $error("last flag on a path or visited word");
endmodule

// ===== rtl/gdfs_ctrl.sv =====
// Controller state machine of the path search block.
// Depends on gdfs_pkg; drives the datapath only through t_dp_cmd.
module gdfs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_op,
    output logic               o_in_ready,
    input  gdfs_pkg::t_dp_stat i_stat,
    output gdfs_pkg::t_dp_cmd  o_cmd
);
    import gdfs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (i_stat.in_range) begin
                        o_cmd.init = 1'b1;
                        n_state    = S_STEP;
                    end else begin
                        n_state = S_OUT_BAD;
                    end
                end
            end
            S_STEP: begin
                if (i_stat.stack_empty) begin
                    n_state = S_OUT_SUM;
                end else if (i_stat.top_is_goal) begin
                    o_cmd.set_found = 1'b1;
                    n_state         = S_OUT_PATH;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // The edge cost is read here and lands in time for the push.
                if (i_stat.push_ok) begin
                    n_state = S_PUSH;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_STEP;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_STEP;
            end
            S_OUT_PATH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_path = 1'b1;
                    if (i_stat.path_last) n_state = S_OUT_SUM;
                end
            end
            S_OUT_SUM: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sum = 1'b1;
                    n_state        = S_OUT_VIS;
                end
            end
            S_OUT_VIS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_vis = 1'b1;
                    if (i_stat.vis_last) n_state = S_OUT_GEN;
                end
            end
            S_OUT_GEN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_gen = 1'b1;
                    if (i_stat.gen_last) n_state = S_IDLE;
                end
            end
            S_OUT_BAD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_bad = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== rtl/gdfs_dpath.sv =====
// Datapath of the path search block: adjacency bits, cost memory, stacks,
// order lists and the result register. Depends on gdfs_pkg.
module gdfs_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [gdfs_pkg::CNT_W-1:0]      i_count,
    input  logic [gdfs_pkg::VW-1:0]         i_vertex_a,
    input  logic [gdfs_pkg::VW-1:0]         i_vertex_b,
    input  logic [15:0]                     i_edge_cost,
    input  logic                            i_edge_present,
    input  gdfs_pkg::t_dp_cmd               i_cmd,
    output gdfs_pkg::t_dp_stat              o_stat,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [1:0]                      o_list_kind,
    output logic [gdfs_pkg::VW-1:0]         o_vertex,
    output logic [gdfs_pkg::SUM_BITS-1:0]   o_path_cost,
    output logic                            o_path_found,
    output logic                            o_last
);
    import gdfs_pkg::*;

    logic [VERTICES-1:0]  r_edge [VERTICES];
    logic [COST_BITS-1:0] r_mem  [VERTICES*VERTICES];
    logic [COST_BITS-1:0] r_cost_rd;
    logic [VERTICES-1:0]  r_vis, r_gen;
    logic [VW-1:0]        r_vorder [VERTICES];
    logic [VW-1:0]        r_gorder [VERTICES];
    logic [VW-1:0]        r_stack  [VERTICES];
    logic [COST_BITS-1:0] r_cstack [VERTICES];
    logic [CNT_W-1:0]     r_depth, r_nvis, r_ngen, r_idx, r_count;
    logic [VW-1:0]        r_goal, r_v, r_pick;
    logic                 r_pick_ok, r_found;
    logic [SUM_BITS-1:0]  r_total;

    logic                 r_ov;
    logic [1:0]           r_kind;
    logic [VW-1:0]        r_vert;
    logic [SUM_BITS-1:0]  r_pcost;
    logic                 r_pfound, r_plast;

    logic [VW-1:0]        top;
    logic                 hit, load_ok, out_free, emit_any;
    logic [VW-1:0]        ld_lo, ld_hi, rd_lo, rd_hi;
    logic [SUM_BITS:0]    sum;

    assign top     = r_stack[VW'(r_depth - CNT_W'(1))];
    assign hit     = r_edge[top][r_v] && !r_vis[r_v];
    assign load_ok = ({1'b0, i_vertex_a} < i_count) && ({1'b0, i_vertex_b} < i_count);
    assign out_free = !r_ov || i_out_ready;
    assign emit_any = i_cmd.emit_path || i_cmd.emit_sum || i_cmd.emit_vis
                      || i_cmd.emit_gen || i_cmd.emit_bad;
    // The cost of an undirected edge is kept once, under the ordered pair.
    assign ld_lo = (i_vertex_a < i_vertex_b) ? i_vertex_a : i_vertex_b;
    assign ld_hi = (i_vertex_a < i_vertex_b) ? i_vertex_b : i_vertex_a;
    assign rd_lo = (top < r_pick) ? top : r_pick;
    assign rd_hi = (top < r_pick) ? r_pick : top;
    assign sum   = {1'b0, r_total} + (SUM_BITS+1)'(r_cstack[VW'(r_idx)]);

    always_comb begin
        o_stat             = '0;
        o_stat.in_range    = load_ok;
        o_stat.stack_empty = (r_depth == '0);
        o_stat.top_is_goal = (top == r_goal);
        o_stat.scan_last   = ({1'b0, r_v} == r_count - CNT_W'(1));
        o_stat.push_ok     = r_pick_ok && (r_depth != CNT_W'(VERTICES))
                             && (r_nvis != CNT_W'(VERTICES));
        o_stat.path_last   = (r_idx == r_depth - CNT_W'(1));
        o_stat.vis_last    = (r_idx == r_nvis - CNT_W'(1));
        o_stat.gen_last    = (r_idx == r_ngen - CNT_W'(1));
        o_stat.out_free    = out_free;
        o_stat.found       = r_found;
        o_stat.depth       = r_depth;
    end

    // Adjacency bits double as valid bits for the cost memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VERTICES; i++) r_edge[i] <= '0;
        end else if (i_cmd.load && load_ok) begin
            r_edge[i_vertex_a][i_vertex_b] <= i_edge_present;
            r_edge[i_vertex_b][i_vertex_a] <= i_edge_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_ok) begin
            r_mem[{ld_lo, ld_hi}] <= i_edge_present ? i_edge_cost[COST_BITS-1:0] : '0;
        end
        r_cost_rd <= r_mem[{rd_lo, rd_hi}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_vis     <= '0;
            r_gen     <= '0;
            r_nvis    <= '0;
            r_ngen    <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_pick_ok <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (emit_any) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.init) begin
                r_vis       <= VERTICES'(1) << i_vertex_a;
                r_gen       <= VERTICES'(1) << i_vertex_a;
                r_stack[0]  <= i_vertex_a;
                r_cstack[0] <= '0;
                r_vorder[0] <= i_vertex_a;
                r_gorder[0] <= i_vertex_a;
                r_depth     <= CNT_W'(1);
                r_nvis      <= CNT_W'(1);
                r_ngen      <= CNT_W'(1);
                r_goal      <= i_vertex_b;
                r_count     <= i_count;
                r_found     <= 1'b0;
                r_idx       <= '0;
                r_total     <= '0;
            end
            if (i_cmd.set_found) r_found <= 1'b1;
            if (i_cmd.scan_start) begin
                r_v       <= '0;
                r_pick_ok <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (hit) begin
                    if (!r_gen[r_v] && r_ngen != CNT_W'(VERTICES)) begin
                        r_gen[r_v]               <= 1'b1;
                        r_gorder[VW'(r_ngen)]    <= r_v;
                        r_ngen                   <= r_ngen + CNT_W'(1);
                    end
                    r_pick    <= r_v;
                    r_pick_ok <= 1'b1;
                end
                r_v <= r_v + VW'(1);
            end
            if (i_cmd.pop) r_depth <= r_depth - CNT_W'(1);
            if (i_cmd.push) begin
                r_stack[VW'(r_depth)]  <= r_pick;
                r_cstack[VW'(r_depth)] <= r_cost_rd;
                r_depth                <= r_depth + CNT_W'(1);
                r_vis[r_pick]          <= 1'b1;
                r_vorder[VW'(r_nvis)]  <= r_pick;
                r_nvis                 <= r_nvis + CNT_W'(1);
            end
            if (i_cmd.emit_path) begin
                r_kind   <= KIND_PATH;
                r_vert   <= r_stack[VW'(r_idx)];
                r_pcost  <= '0;
                r_pfound <= 1'b0;
                r_plast  <= 1'b0;
                r_total  <= sum[SUM_BITS] ? '1 : sum[SUM_BITS-1:0];
                r_idx    <= o_stat.path_last ? '0 : r_idx + CNT_W'(1);
            end
            if (i_cmd.emit_sum || i_cmd.emit_bad) begin
                r_kind   <= KIND_SUM;
                r_vert   <= '0;
                r_pcost  <= (r_found && i_cmd.emit_sum) ? r_total : '0;
                r_pfound <= r_found && i_cmd.emit_sum;
                r_plast  <= i_cmd.emit_bad;
                r_idx    <= '0;
            end
            if (i_cmd.emit_vis) begin
                r_kind   <= KIND_VIS;
                r_vert   <= r_vorder[VW'(r_idx)];
                r_pcost  <= '0;
                r_pfound <= 1'b0;
                r_plast  <= 1'b0;
                r_idx    <= o_stat.vis_last ? '0 : r_idx + CNT_W'(1);
            end
            if (i_cmd.emit_gen) begin
                r_kind   <= KIND_GEN;
                r_vert   <= r_gorder[VW'(r_idx)];
                r_pcost  <= '0;
                r_pfound <= 1'b0;
                r_plast  <= o_stat.gen_last;
                r_idx    <= o_stat.gen_last ? '0 : r_idx + CNT_W'(1);
            end
        end
    end

    assign o_out_valid  = r_ov;
    assign o_list_kind  = r_kind;
    assign o_vertex     = r_vert;
    assign o_path_cost  = r_pcost;
    assign o_path_found = r_pfound;
    assign o_last       = r_plast;
endmodule

// ===== bench/gdfs_search_checker.sv =====
// Checker for the depth-first path search block: watches both channels,
// predicts the result words of every accepted search and compares them.
// Depends on gdfs_pkg, gdfs_in_if and gdfs_out_if.
`timescale 1ns / 100ps

module gdfs_search_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gdfs_in_if          s_in,
    gdfs_out_if         m_out,
    input  logic [4:0]  i_vertex_count,
    output int          o_fail_count,
    output int          o_pending
);
    import gdfs_pkg::*;

    typedef struct packed {
        logic [1:0]          list_kind;
        logic [VW-1:0]       vertex;
        logic [SUM_BITS-1:0] path_cost;
        logic                path_found;
        logic                last;
    } t_result;

    t_result             expected_words[$];
    logic [COST_BITS-1:0] graph_cost[VERTICES][VERTICES];
    logic                graph_edge[VERTICES][VERTICES];

    assign o_pending = expected_words.size();

    function automatic t_result make_word(logic [1:0] k, logic [VW-1:0] v,
                                          logic [SUM_BITS-1:0] c, logic f, logic l);
        t_result r;
        r.list_kind = k;
        r.vertex = v;
        r.path_cost = c;
        r.path_found = f;
        r.last = l;
        return r;
    endfunction

    task automatic queue_word(t_result w);
        expected_words.insert(expected_words.size(), w);
    endtask

    // Walks the graph exactly as the block does and queues the result words.
    task automatic predict_search(logic [VW-1:0] start_v, logic [VW-1:0] goal_v);
        int count;
        bit seen[VERTICES];
        bit gen_flag[VERTICES];
        int visit_list[$];
        int gen_list[$];
        int path[$];
        int step_cost[$];
        int top;
        int pick;
        bit reached;
        int total;
        count = i_vertex_count < 2 ? 2 : (i_vertex_count > VERTICES ? VERTICES
                                                                    : i_vertex_count);
        if (start_v >= count || goal_v >= count) begin
            queue_word(make_word(KIND_SUM, VW'(0), SUM_BITS'(0), 1'b0, 1'b1));
            return;
        end
        foreach (seen[i]) begin
            seen[i] = 0;
            gen_flag[i] = 0;
        end
        reached = 0;
        total = 0;
        path.insert(path.size(), int'(start_v));
        step_cost.insert(step_cost.size(), 0);
        seen[start_v] = 1;
        gen_flag[start_v] = 1;
        visit_list.insert(visit_list.size(), int'(start_v));
        gen_list.insert(gen_list.size(), int'(start_v));
        while (path.size() > 0) begin
            top = path[$];
            pick = -1;
            if (top == goal_v) begin
                reached = 1;
                break;
            end
            for (int v = 0; v < count; v++) begin
                if (!graph_edge[top][v] || seen[v]) continue;
                if (!gen_flag[v] && gen_list.size() < VERTICES) begin
                    gen_flag[v] = 1;
                    gen_list.insert(gen_list.size(), v);
                end
                pick = v;
            end
            if (pick < 0 || path.size() >= VERTICES || visit_list.size() >= VERTICES) begin
                path.delete(path.size() - 1);
                step_cost.delete(step_cost.size() - 1);
            end else begin
                path.insert(path.size(), pick);
                step_cost.insert(step_cost.size(), int'(graph_cost[top][pick]));
                seen[pick] = 1;
                visit_list.insert(visit_list.size(), pick);
            end
        end
        if (reached) begin
            foreach (path[i]) begin
                total += step_cost[i];
                if (total > 20'hFFFFF) total = 20'hFFFFF;
                queue_word(make_word(KIND_PATH, VW'(path[i]), SUM_BITS'(0), 1'b0, 1'b0));
            end
        end
        queue_word(make_word(KIND_SUM, VW'(0), reached ? SUM_BITS'(total) : SUM_BITS'(0),
                             reached, 1'b0));
        foreach (visit_list[i])
            queue_word(make_word(KIND_VIS, VW'(visit_list[i]), SUM_BITS'(0), 1'b0, 1'b0));
        foreach (gen_list[i])
            queue_word(make_word(KIND_GEN, VW'(gen_list[i]), SUM_BITS'(0), 1'b0,
                                 i == gen_list.size() - 1));
    endtask

    task automatic compare_word(t_result got);
        t_result want;
        if (expected_words.size() == 0) begin
            $error("result word with none expected: kind %0d vertex %0d",
                   got.list_kind, got.vertex);
            o_fail_count++;
            return;
        end
        want = expected_words.pop_front();
        if (got.list_kind !== want.list_kind) begin
            $error("list_kind expected %0d actual %0d", want.list_kind, got.list_kind);
            o_fail_count++;
        end
        if (got.vertex !== want.vertex) begin
            $error("vertex expected %0d actual %0d", want.vertex, got.vertex);
            o_fail_count++;
        end
        if (got.path_cost !== want.path_cost) begin
            $error("path_cost expected %0d actual %0d", want.path_cost, got.path_cost);
            o_fail_count++;
        end
        if (got.path_found !== want.path_found) begin
            $error("path_found expected %0d actual %0d", want.path_found, got.path_found);
            o_fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, got.last);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        int count;
        if (!i_rst_n) begin
            foreach (graph_edge[i, j]) begin
                graph_edge[i][j] = 0;
                graph_cost[i][j] = 0;
            end
        end else begin
            if (m_out.valid && m_out.ready)
                compare_word(make_word(m_out.list_kind, m_out.vertex, m_out.path_cost,
                                       m_out.path_found, m_out.last));
            if (s_in.valid && s_in.ready) begin
                count = i_vertex_count < 2 ? 2 : (i_vertex_count > VERTICES ? VERTICES
                                                                            : i_vertex_count);
                if (s_in.operation == OP_SEARCH) begin
                    predict_search(s_in.vertex_a, s_in.vertex_b);
                end else if (s_in.vertex_a < count && s_in.vertex_b < count) begin
                    graph_edge[s_in.vertex_a][s_in.vertex_b] = s_in.edge_present;
                    graph_edge[s_in.vertex_b][s_in.vertex_a] = s_in.edge_present;
                    graph_cost[s_in.vertex_a][s_in.vertex_b] =
                        s_in.edge_present ? s_in.edge_cost : '0;
                    graph_cost[s_in.vertex_b][s_in.vertex_a] =
                        s_in.edge_present ? s_in.edge_cost : '0;
                end
            end
        end
    end
endmodule

// ===== bench/graph_depth_first_path_search_tb.sv =====
// Testbench top for the depth-first path search block: clock, reset, register
// writes, load and search stimulus and the verdict.
// Depends on gdfs_pkg, the channel interfaces, gdfs_search_checker and the block.
`timescale 1ns / 100ps

module graph_depth_first_path_search_tb;
    import gdfs_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic [4:0]  vertex_count_shadow;
    int          fail_count;
    int          pending_words;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cycle_count = 0;

    gdfs_in_if  in_ch();
    gdfs_out_if out_ch();

    graph_depth_first_path_search dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(in_ch.sink), .m_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    gdfs_search_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(in_ch), .m_out(out_ch),
        .i_vertex_count(vertex_count_shadow), .o_fail_count(fail_count),
        .o_pending(pending_words)
    );

    initial i_clk = 0;
    always #6 i_clk = ~i_clk;

    // A search can emit up to 49 result words, each of which may stall; allow plenty.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic write_vertex_count(logic [4:0] value);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {REG_VERTEX_COUNT, 2'b00};
        pwdata <= {27'b0, value};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        vertex_count_shadow <= value;
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic send_word(logic op, logic [3:0] a, logic [3:0] b, logic [15:0] c,
                             logic p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.operation <= op;
        in_ch.vertex_a <= a;
        in_ch.vertex_b <= b;
        in_ch.edge_cost <= c;
        in_ch.edge_present <= p;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        // The last word of a load leaves nothing to wait on; give the block time.
        repeat (400) @(posedge i_clk);
    endtask

    // Random loads on the first n vertices, some searches and some random words.
    task automatic random_phase(int n, int items);
        int k;
        for (k = 0; k < items; k++) begin
            if ($urandom_range(99) < 65)
                send_word(OP_LOAD, 4'($urandom_range(n - 1)), 4'($urandom_range(n - 1)),
                          16'($urandom), $urandom_range(99) < 75);
            else if ($urandom_range(99) < 90)
                send_word(OP_SEARCH, 4'($urandom_range(n - 1)), 4'($urandom_range(n - 1)),
                          16'($urandom), 1'($urandom));
            else
                send_word(1'($urandom), 4'($urandom), 4'($urandom), 16'($urandom),
                          1'($urandom));
        end
    endtask

    initial begin
        int v;
        send_idle_pct = 36;
        recv_idle_pct = 69;
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        vertex_count_shadow = 16;
        in_ch.valid = 0;
        in_ch.operation = OP_LOAD;
        in_ch.vertex_a = 0;
        in_ch.vertex_b = 0;
        in_ch.edge_cost = 0;
        in_ch.edge_present = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: chain 0..15 with extreme costs, then searches.
        for (v = 0; v < 15; v++)
            send_word(OP_LOAD, 4'(v), 4'(v + 1), v[0] ? 16'hFFFF : 16'h0000, 1'b1);
        send_word(OP_LOAD, 4'd3, 4'd3, 16'h5555, 1'b1);
        send_word(OP_SEARCH, 4'd0, 4'd15, 16'd0, 1'b0);
        send_word(OP_SEARCH, 4'd7, 4'd7, 16'd0, 1'b0);
        send_word(OP_LOAD, 4'd7, 4'd8, 16'hAAAA, 1'b0);
        send_word(OP_SEARCH, 4'd15, 4'd0, 16'hFFFF, 1'b1);
        drain_results();

        write_vertex_count(5'd4);
        send_word(OP_LOAD, 4'd3, 4'd9, 16'h1234, 1'b1);
        send_word(OP_SEARCH, 4'd0, 4'd9, 16'd0, 1'b0);
        send_word(OP_SEARCH, 4'd0, 4'd3, 16'd0, 1'b0);
        drain_results();
        write_vertex_count(5'd0);
        send_word(OP_SEARCH, 4'd1, 4'd0, 16'd0, 1'b0);
        send_word(OP_SEARCH, 4'd0, 4'd2, 16'd0, 1'b0);
        drain_results();
        write_vertex_count(5'd31);

        random_phase(16, 90);
        drain_results();
        send_idle_pct = 69;
        recv_idle_pct = 36;
        write_vertex_count(5'd6);
        random_phase(6, 80);
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_vertex_count(5'd16);
        random_phase(16, 80);
        drain_results();

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/gdfs_pkg.sv
rtl/gdfs_in_if.sv
rtl/gdfs_out_if.sv
rtl/gdfs_ctrl.sv
rtl/gdfs_dpath.sv
rtl/graph_depth_first_path_search.sv
bench/gdfs_search_checker.sv
bench/graph_depth_first_path_search_tb.sv
